/* rtl/core/bdq_pkg.sv */
// Shared types and constants for the bounded double-ended queue.
// Command and status codes, FSM states and the input/output word structs.
// No dependencies.
package bdq_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int ENTRY_W = 5;

	localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_PUSH_BACK  = 2'd0,
		CMD_PUSH_FRONT = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_BACK   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_UNDERFLOW = 2'd1,
		STS_OVERFLOW  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	typedef struct packed {
		cmd_t                      command;
		logic signed [DATA_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] back_value;
		logic [ENTRY_W-1:0]       entry_count;
		logic                     is_empty;
		status_t                  status;
	} out_word_t;

endpackage

/* rtl/core/bdq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Self-contained; width and depth set by parameters.
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/core/bdq_ctrl.sv */
// Deque control: front/back pointers, count, cached end values, RAM access.
// Depends on bdq_pkg; drives the bdq_ram ports and hands results to the top.
module bdq_ctrl
	import bdq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_word_t          in_data,
	input  logic              res_room,
	output logic              res_valid,
	output out_word_t         res_data,
	output logic              wr_en,
	output logic [IDX_W-1:0]  wr_addr,
	output logic [DATA_W-1:0] wr_data,
	output logic              rd_en,
	output logic [IDX_W-1:0]  rd_addr,
	input  logic [DATA_W-1:0] rd_data
);

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  front_idx_q, front_idx_d;
	logic [IDX_W-1:0]  back_idx_q, back_idx_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [DATA_W-1:0] front_val_q, front_val_d;
	logic [DATA_W-1:0] back_val_q, back_val_d;
	logic              rd_front_q, rd_front_d;
	logic              accept, is_full, is_none, need_read;
	status_t           status;
	logic [CNT_W+ENTRY_W-1:0] count_ext;

	assign accept  = in_valid && in_ready;
	assign is_full = (count_q == CNT_W'(DEPTH));
	assign is_none = (count_q == '0);

	// Datapath: next pointers, count and cached end values.
	always_comb begin
		front_idx_d = front_idx_q;
		back_idx_d  = back_idx_q;
		count_d     = count_q;
		front_val_d = front_val_q;
		back_val_d  = back_val_q;
		rd_front_d  = rd_front_q;
		status      = STS_OK;
		need_read   = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = back_idx_q;
		wr_data     = in_data.value;
		rd_addr     = front_idx_q;
		if (state_q == S_READ) begin
			if (rd_front_q) begin
				front_val_d = rd_data;
			end else begin
				back_val_d = rd_data;
			end
		end else if (accept) begin
			case (in_data.command)
				CMD_PUSH_BACK: begin
					if (is_full) begin
						status = STS_OVERFLOW;
					end else begin
						back_idx_d = idx_inc(back_idx_q);
						wr_en      = 1'b1;
						wr_addr    = back_idx_d;
						count_d    = count_q + 1'b1;
						back_val_d = in_data.value;
						if (is_none) front_val_d = in_data.value;
					end
				end
				CMD_PUSH_FRONT: begin
					if (is_full) begin
						status = STS_OVERFLOW;
					end else begin
						front_idx_d = idx_dec(front_idx_q);
						wr_en       = 1'b1;
						wr_addr     = front_idx_d;
						count_d     = count_q + 1'b1;
						front_val_d = in_data.value;
						if (is_none) back_val_d = in_data.value;
					end
				end
				CMD_POP_FRONT: begin
					if (is_none) begin
						status = STS_UNDERFLOW;
					end else begin
						front_idx_d = idx_inc(front_idx_q);
						count_d     = count_q - 1'b1;
						rd_addr     = front_idx_d;
						rd_front_d  = 1'b1;
						need_read   = (count_d != '0);
					end
				end
				CMD_POP_BACK: begin
					if (is_none) begin
						status = STS_UNDERFLOW;
					end else begin
						back_idx_d = idx_dec(back_idx_q);
						count_d    = count_q - 1'b1;
						rd_addr    = back_idx_d;
						rd_front_d = 1'b0;
						need_read  = (count_d != '0);
					end
				end
				default: begin
					status = STS_OK;
				end
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (accept && need_read) state_d = S_READ;
			S_READ:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// FSM outputs.
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		rd_en     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready  = res_room;
				rd_en     = accept && need_read;
				res_valid = accept && !need_read;
			end
			S_READ: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Result word built from the post-step state.
	assign count_ext = {{ENTRY_W{1'b0}}, count_d};
	always_comb begin
		res_data.entry_count = count_ext[ENTRY_W-1:0];
		res_data.is_empty    = (count_d == '0);
		res_data.status      = status;
		res_data.front_value = (count_d == '0) ? INT_MIN : front_val_d;
		res_data.back_value  = (count_d == '0) ? INT_MIN : back_val_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_idx_q <= '0;
			back_idx_q  <= IDX_W'(DEPTH - 1);
			count_q     <= '0;
			rd_front_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			front_idx_q <= front_idx_d;
			back_idx_q  <= back_idx_d;
			count_q     <= count_d;
			rd_front_q  <= rd_front_d;
		end
	end

	always_ff @(posedge clk) begin
		front_val_q <= front_val_d;
		back_val_q  <= back_val_d;
	end

endmodule

/* rtl/core/bounded_double_ended_queue_top.sv */
// Top level of the bounded double-ended queue: control, slot RAM, output register.
// Depends on bdq_pkg, bdq_ram and bdq_ctrl.
//
// Deque of signed 32-bit values, DEPTH slots in a circular RAM. Each input word is
// a command (push back, push front, pop front, pop back) and gives one output
// word with the front and back values, the count, an empty flag and a status.
// Pushes, failed commands and pops that empty the queue give their result directly;
// a pop that leaves values behind passes through S_READ, as the new end value comes from
// the RAM's registered read port. The front and back values are cached in registers.
// An output register holds the result; a word is taken when it is empty or drained.
module bounded_double_ended_queue_top
	import bdq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	logic              res_room, res_valid;
	out_word_t         res_data;
	logic              wr_en, rd_en;
	logic [IDX_W-1:0]  wr_addr, rd_addr;
	logic [DATA_W-1:0] wr_data, rd_data;
	logic              out_valid_q;
	out_word_t         out_data_q;

	assign res_room = !out_valid_q || out_ready;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_room  (res_room),
		.res_valid (res_valid),
		.res_data  (res_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	bdq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
